### rtl/dem_pkg.sv
// Package for the delta E color match unit: widths, constant tables, shared types.
`timescale 1ns / 1ps
package dem_pkg;

  localparam int FRAC_BITS = 16;

  localparam int LIN_W   = FRAC_BITS + 1;
  localparam int COEF_W  = FRAC_BITS;
  localparam int PROD_W  = LIN_W + COEF_W;
  localparam int XYZ_W   = FRAC_BITS + 2;
  localparam int T_W     = FRAC_BITS + 2;
  localparam int M_W     = FRAC_BITS + 3;
  localparam int DP_W    = XYZ_W + M_W;
  localparam int Q0_W    = FRAC_BITS + 3;
  localparam int NW      = FRAC_BITS + 23;
  localparam int F_W     = FRAC_BITS + 1;
  localparam int CB      = FRAC_BITS + 1;
  localparam int LN_W    = FRAC_BITS - 6;
  localparam int LP_W    = LN_W + FRAC_BITS;
  localparam int LNN_W   = LN_W + 24;
  localparam int DF_W    = F_W + 3;
  localparam int P_W     = DF_W + 10;
  localparam int MAG_W   = P_W - 1;
  localparam int Q_W     = 18;
  localparam int SUM_W   = 36;

  localparam int FRONT_LAT = 6;
  localparam int CIEF_LAT  = 2 * CB + 1;
  localparam int DIST_LAT  = 5;
  localparam int CORE_LAT  = FRONT_LAT + CIEF_LAT + DIST_LAT;

  // divisions by the white point, X then Z
  localparam longint unsigned DIV_D   [2] = '{64'd950489, 64'd1088840};
  localparam longint unsigned DIV_OFF [2] = '{64'd475244, 64'd544420};
  localparam longint unsigned DIV_M   [2] = '{
    (64'd1000000 << (FRAC_BITS + 2)) / 64'd950489,
    (64'd1000000 << (FRAC_BITS + 2)) / 64'd1088840
  };

  localparam longint unsigned CUBE_TH = (64'd8856 << FRAC_BITS) / 64'd1000000;
  localparam longint unsigned LIN_M   = (64'd7787037 << LN_W) / 64'd1000000;
  localparam longint unsigned LIN_C4  = ((64'd4 << FRAC_BITS) + 64'd14) / 64'd29;

  typedef logic [2:0][7:0]       rgb_t;
  typedef logic [2:0][T_W-1:0]   tvec_t;
  typedef logic [2:0][F_W-1:0]   fvec_t;
  typedef logic [LIN_W-1:0]      lin_tab_t [256];
  typedef logic [COEF_W-1:0]     coef_tab_t [9];

  typedef struct packed {
    logic             big;
    logic [SUM_W-1:0] sum;
  } dist_res_t;

  function automatic longint unsigned pow5_q30(longint unsigned y);
    longint unsigned p;
    p = (y * y) >> 30;
    p = (p * y) >> 30;
    p = (p * y) >> 30;
    p = (p * y) >> 30;
    return p;
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t        tab;
    longint unsigned v;
    longint unsigned w;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned lin;
    for (int c = 0; c < 256; c++) begin
      if (c >= 11) begin
        v  = ((64'(1000 * c + 14025) << 30) + 64'd134512) / 64'd269025;
        w  = (v * v) >> 30;
        lo = 64'd0;
        hi = (64'd1 << 30) + 64'd1;
        while (hi - lo > 64'd1) begin
          mid = lo + (hi - lo) / 64'd2;
          if (pow5_q30(mid) <= w) lo = mid;
          else hi = mid;
        end
        lin = (w * lo + (64'd1 << 29)) >> 30;
      end else begin
        lin = ((64'(100 * c) << 30) + 64'd164730) / 64'd329460;
      end
      tab[c] = LIN_W'((lin + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end
    return tab;
  endfunction

  function automatic logic [COEF_W-1:0] coef_q(longint unsigned k);
    return COEF_W'((k * (64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();

  localparam coef_tab_t COEF = '{
    coef_q(64'd412453), coef_q(64'd357580), coef_q(64'd180423),
    coef_q(64'd212671), coef_q(64'd715160), coef_q(64'd72169),
    coef_q(64'd19334),  coef_q(64'd119193), coef_q(64'd950227)
  };

endpackage

### rtl/delta_e_color_match_unit.sv
// Top level of the CIE76 delta E color match unit with stream ports.
`timescale 1ns / 1ps
// Compares two 8-bit sRGB colors per beat in CIE Lab space and reports whether
// delta E is within the given whole-unit tolerance (identical colors always match).
// One beat is accepted every clock while the skid register is empty. The depth
// of the pipeline is set mostly by the cube-root pipeline, which spends two stages
// per result bit. A skid register at the output keeps the input side taking
// beats while one result waits on m_axis_tready.
module delta_e_color_match_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_red[7:0], first_green[15:8], first_blue[23:16], second_red[31:24],
  // second_green[39:32], second_blue[47:40], tolerance[56:48], zero[63:57]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // colours_match[0], zero[7:1]
  output logic [7:0]  m_axis_tdata
);
  import dem_pkg::*;

  logic           en;
  logic           v0_q;
  rgb_t           rgb1_q;
  rgb_t           rgb2_q;
  logic [8:0]     tol0_q;
  logic           same0_q;
  logic           dv_q    [CORE_LAT];
  logic [8:0]     dtol_q  [CORE_LAT];
  logic           dsame_q [CORE_LAT];
  tvec_t          t1;
  tvec_t          t2;
  fvec_t          f1;
  fvec_t          f2;
  dist_res_t      dres;
  logic           pv_q;
  logic           pm_q;
  logic           pm_d;
  logic           ov_q;
  logic           om_q;
  logic           sv_q;
  logic           sm_q;
  logic [SUM_W-1:0] lim_d;

  assign en            = ~sv_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      pv_q <= 1'b0;
      for (int i = 0; i < CORE_LAT; i++) begin
        dv_q[i] <= 1'b0;
      end
    end else if (en) begin
      v0_q    <= s_axis_tvalid;
      dv_q[0] <= v0_q;
      for (int i = 1; i < CORE_LAT; i++) begin
        dv_q[i] <= dv_q[i-1];
      end
      pv_q <= dv_q[CORE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rgb1_q     <= s_axis_tdata[23:0];
      rgb2_q     <= s_axis_tdata[47:24];
      tol0_q     <= s_axis_tdata[56:48];
      same0_q    <= s_axis_tdata[23:0] == s_axis_tdata[47:24];
      dtol_q[0]  <= tol0_q;
      dsame_q[0] <= same0_q;
      for (int i = 1; i < CORE_LAT; i++) begin
        dtol_q[i]  <= dtol_q[i-1];
        dsame_q[i] <= dsame_q[i-1];
      end
      pm_q <= pm_d;
    end
  end

  dem_front u_front1 (.clk_i(clk_i), .en_i(en), .rgb_i(rgb1_q), .t_o(t1));
  dem_front u_front2 (.clk_i(clk_i), .en_i(en), .rgb_i(rgb2_q), .t_o(t2));

  for (genvar c = 0; c < 3; c++) begin : g_chan
    dem_cief u_cief1 (.clk_i(clk_i), .en_i(en), .t_i(t1[c]), .f_o(f1[c]));
    dem_cief u_cief2 (.clk_i(clk_i), .en_i(en), .t_i(t2[c]), .f_o(f2[c]));
  end

  dem_dist u_dist (.clk_i(clk_i), .en_i(en), .f1_i(f1), .f2_i(f2), .res_o(dres));

  assign lim_d = SUM_W'(dtol_q[CORE_LAT-1]) * SUM_W'(dtol_q[CORE_LAT-1]) << 16;
  assign pm_d  = dsame_q[CORE_LAT-1] | (~dres.big & (dres.sum <= lim_d));

  // output register plus skid beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (ov_q && !m_axis_tready) begin
      if (en && pv_q) sv_q <= 1'b1;
    end else if (sv_q) begin
      ov_q <= 1'b1;
      sv_q <= 1'b0;
    end else begin
      ov_q <= en & pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ov_q && !m_axis_tready) begin
      if (en && pv_q) sm_q <= pm_q;
    end else if (sv_q) begin
      om_q <= sm_q;
    end else if (en && pv_q) begin
      om_q <= pm_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'b0, om_q};

endmodule

### rtl/dem_front.sv
// Front end: gamma table, RGB to XYZ matrix and white point scaling for one color.
`timescale 1ns / 1ps
module dem_front (
  input  logic          clk_i,
  input  logic          en_i,
  input  dem_pkg::rgb_t rgb_i,
  output dem_pkg::tvec_t t_o
);
  import dem_pkg::*;

  logic [LIN_W-1:0]  lin_q  [3];
  logic [PROD_W-1:0] prod_q [9];
  logic [XYZ_W-1:0]  xyz_q  [3];
  logic [DP_W-1:0]   dp_q   [2];
  logic [NW-1:0]     n1_q   [2];
  logic [Q0_W-1:0]   q0_q   [2];
  logic [NW-1:0]     qd_q   [2];
  logic [NW-1:0]     n2_q   [2];
  logic [XYZ_W-1:0]  y1_q;
  logic [XYZ_W-1:0]  y2_q;
  logic [T_W-1:0]    t_q    [3];

  logic [PROD_W+1:0] sum_d  [3];
  logic [Q0_W-1:0]   q0_d   [2];
  logic [NW-1:0]     rem_d  [2];
  logic [T_W-1:0]    tdiv_d [2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = (PROD_W+2)'(prod_q[3*i]) + (PROD_W+2)'(prod_q[3*i+1])
               + (PROD_W+2)'(prod_q[3*i+2]);
    end
    for (int i = 0; i < 2; i++) begin
      q0_d[i]   = Q0_W'(dp_q[i] >> (FRAC_BITS + 2));
      rem_d[i]  = n2_q[i] - qd_q[i];
      tdiv_d[i] = T_W'(q0_q[i]) + T_W'(rem_d[i] >= NW'(DIV_D[i]))
                + T_W'(rem_d[i] >= NW'(2 * DIV_D[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        lin_q[i] <= LIN_TAB[rgb_i[i]];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[3*i+j] <= PROD_W'(lin_q[j]) * PROD_W'(COEF[3*i+j]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        xyz_q[i] <= XYZ_W'((sum_d[i] + (PROD_W+2)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      end
      for (int i = 0; i < 2; i++) begin
        dp_q[i] <= DP_W'(xyz_q[2*i]) * DP_W'(DIV_M[i]);
        n1_q[i] <= NW'(xyz_q[2*i]) * NW'(1000000) + NW'(DIV_OFF[i]);
        q0_q[i] <= q0_d[i];
        qd_q[i] <= NW'(q0_d[i]) * NW'(DIV_D[i]);
        n2_q[i] <= n1_q[i];
      end
      y1_q   <= xyz_q[1];
      y2_q   <= y1_q;
      t_q[0] <= tdiv_d[0];
      t_q[1] <= T_W'(y2_q);
      t_q[2] <= tdiv_d[1];
    end
  end

  assign t_o[0] = t_q[0];
  assign t_o[1] = t_q[1];
  assign t_o[2] = t_q[2];

endmodule

### rtl/dem_cief.sv
// CIE f(t) for one channel: bit-per-two-stage cube root and the linear segment.
`timescale 1ns / 1ps
module dem_cief (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [dem_pkg::T_W-1:0] t_i,
  output logic [dem_pkg::F_W-1:0] f_o
);
  import dem_pkg::*;

  // linear segment
  logic [LP_W-1:0]  lp_q;
  logic [LNN_W-1:0] ln1_q;
  logic [F_W-1:0]   lq0_q;
  logic [LNN_W-1:0] lqd_q;
  logic [LNN_W-1:0] ln2_q;
  logic [F_W-1:0]   lind_q [2*CB-2];
  logic             sel_q  [2*CB];
  logic [LN_W-1:0]  tl_d;
  logic [F_W-1:0]   lq0_d;
  logic [LNN_W-1:0] lrem_d;
  logic [F_W-1:0]   lin_d;

  // cube root stages
  logic [CB-1:0]    am_q  [CB];
  logic [CB-1:0]    ay_q  [CB];
  logic [CB:0]      asq_q [CB];
  logic [T_W-1:0]   at_q  [CB];
  logic [CB-1:0]    yb_q  [CB];
  logic [T_W-1:0]   tb_q  [CB];
  logic [F_W-1:0]   f_q;

  assign tl_d   = t_i[LN_W-1:0];
  assign lq0_d  = F_W'(lp_q >> LN_W);
  assign lrem_d = ln2_q - lqd_q;
  assign lin_d  = lq0_q + F_W'(lrem_d >= LNN_W'(1000000))
                + F_W'(lrem_d >= LNN_W'(2000000)) + F_W'(LIN_C4);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lp_q      <= LP_W'(tl_d) * LP_W'(LIN_M);
      ln1_q     <= LNN_W'(tl_d) * LNN_W'(7787037) + LNN_W'(500000);
      lq0_q     <= lq0_d;
      lqd_q     <= LNN_W'(lq0_d) * LNN_W'(1000000);
      ln2_q     <= ln1_q;
      lind_q[0] <= lin_d;
      for (int i = 1; i < 2*CB-2; i++) begin
        lind_q[i] <= lind_q[i-1];
      end
      sel_q[0] <= (64'(t_i) > CUBE_TH);
      for (int i = 1; i < 2*CB; i++) begin
        sel_q[i] <= sel_q[i-1];
      end
      f_q <= sel_q[2*CB-1] ? F_W'(yb_q[CB-1]) : lind_q[2*CB-3];
    end
  end

  for (genvar k = 0; k < CB; k++) begin : g_bit
    logic [CB-1:0]     py_d;
    logic [T_W-1:0]    pt_d;
    logic [CB-1:0]     mid_d;
    logic [2*CB-1:0]   sqf_d;
    logic [2*CB:0]     cbf_d;
    logic [CB+1:0]     cube_d;

    if (k == 0) begin : g_first
      assign py_d = '0;
      assign pt_d = t_i;
    end else begin : g_next
      assign py_d = yb_q[k-1];
      assign pt_d = tb_q[k-1];
    end

    assign mid_d  = py_d | (CB'(1) << (CB - 1 - k));
    assign sqf_d  = (2*CB)'(mid_d) * (2*CB)'(mid_d);
    assign cbf_d  = (2*CB+1)'(asq_q[k]) * (2*CB+1)'(am_q[k]);
    assign cube_d = (CB+2)'(cbf_d >> FRAC_BITS);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        am_q[k]  <= mid_d;
        ay_q[k]  <= py_d;
        asq_q[k] <= (CB+1)'(sqf_d >> FRAC_BITS);
        at_q[k]  <= pt_d;
        yb_q[k]  <= ((CB+2)'(cube_d) <= (CB+2)'(at_q[k])) ? am_q[k] : ay_q[k];
        tb_q[k]  <= at_q[k];
      end
    end
  end

  assign f_o = f_q;

endmodule

### rtl/dem_dist.sv
// Lab difference: scaled deltas, magnitude check, Q.8 squares and their sum.
`timescale 1ns / 1ps
module dem_dist (
  input  logic               clk_i,
  input  logic               en_i,
  input  dem_pkg::fvec_t     f1_i,
  input  dem_pkg::fvec_t     f2_i,
  output dem_pkg::dist_res_t res_o
);
  import dem_pkg::*;

  logic signed [DF_W-1:0] df_d [3];
  logic signed [DF_W-1:0] d_q  [3];
  logic signed [P_W-1:0]  p_d  [3];
  logic [MAG_W-1:0]       m_q  [3];
  logic [Q_W-1:0]         q_q  [3];
  logic                   big_q [3];
  logic                   big_any_q;
  logic [SUM_W-1:0]       sq_q [3];
  dist_res_t              res_q;

  localparam logic signed [P_W-1:0] KS [3] = '{P_W'(116), P_W'(500), P_W'(200)};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df_d[i] = $signed(DF_W'(f1_i[i])) - $signed(DF_W'(f2_i[i]));
      p_d[i]  = $signed({{(P_W-DF_W){d_q[i][DF_W-1]}}, d_q[i]}) * KS[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= df_d[1];
      d_q[1] <= df_d[0] - df_d[1];
      d_q[2] <= df_d[1] - df_d[2];
      for (int i = 0; i < 3; i++) begin
        m_q[i]   <= p_d[i][P_W-1] ? MAG_W'(-p_d[i]) : MAG_W'(p_d[i]);
        big_q[i] <= m_q[i] > (MAG_W'(512) << FRAC_BITS);
        q_q[i]   <= Q_W'((m_q[i] + MAG_W'(1 << (FRAC_BITS - 9))) >> (FRAC_BITS - 8));
        sq_q[i]  <= SUM_W'(q_q[i]) * SUM_W'(q_q[i]);
      end
      big_any_q <= big_q[0] | big_q[1] | big_q[2];
      res_q.big <= big_any_q;
      res_q.sum <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // big flags pass through big_q and big_any_q, in step with q_q and sq_q
  assign res_o = res_q;

endmodule

### tb/sv/tb_top.sv
// Testbench for delta_e_color_match_unit: random and directed color pairs checked against a Lab predictor.
`timescale 1ns / 1ps
module tb_top;
  import dem_pkg::*;

  localparam int FB       = FRAC_BITS;
  localparam int N_RANDOM = 1530;
  localparam int WD_LIMIT = 3000;

  typedef struct {
    logic [7:0] r1, g1, b1, r2, g2, b2;
    logic [8:0] tol;
  } pair_t;

  class match_scoreboard;
    bit              pending[$];
    int              errors;
    longint unsigned gamma_tab[256];
    longint unsigned mtx[9];

    function new();
      longint unsigned k[9] = '{412453, 357580, 180423, 212671, 715160, 72169,
                                19334, 119193, 950227};
      errors = 0;
      for (int c = 0; c < 256; c++) gamma_tab[c] = srgb_to_linear(c);
      for (int i = 0; i < 9; i++) mtx[i] = (k[i] * (64'd1 << FB) + 64'd500000) / 64'd1000000;
    endfunction

    function longint unsigned fifth_pow(longint unsigned y);
      longint unsigned p;
      p = (y * y) >> 30;
      repeat (3) p = (p * y) >> 30;
      return p;
    endfunction

    function longint unsigned srgb_to_linear(longint unsigned c);
      longint unsigned v, w, lo, hi, mid, lin;
      if (c >= 11) begin
        v  = (((1000 * c + 14025) << 30) + 134512) / 269025;
        w  = (v * v) >> 30;
        lo = 0;
        hi = (64'd1 << 30) + 1;
        while (hi - lo > 1) begin
          mid = lo + (hi - lo) / 2;
          if (fifth_pow(mid) <= w) lo = mid;
          else hi = mid;
        end
        lin = (w * lo + (64'd1 << 29)) >> 30;
      end else begin
        lin = (((100 * c) << 30) + 164730) / 329460;
      end
      return (lin + (64'd1 << (29 - FB))) >> (30 - FB);
    endfunction

    function longint unsigned lab_f(longint unsigned t);
      longint unsigned lo, hi, mid, q;
      if (t * 1000000 > (64'd8856 << FB)) begin
        lo = 0;
        hi = 64'd1 << (FB + 1);
        while (hi - lo > 1) begin
          mid = lo + (hi - lo) / 2;
          q   = (mid * mid) >> FB;
          if (((q * mid) >> FB) <= t) lo = mid;
          else hi = mid;
        end
        return lo;
      end
      return (t * 7787037 + 500000) / 1000000 + ((64'd4 << FB) + 14) / 29;
    endfunction

    function void color_to_f(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             output longint fv[3]);
      longint unsigned lin[3], xyz[3], s;
      lin = '{gamma_tab[r], gamma_tab[g], gamma_tab[b]};
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int j = 0; j < 3; j++) s += lin[j] * mtx[i*3 + j];
        xyz[i] = (s + (64'd1 << (FB - 1))) >> FB;
      end
      fv[0] = lab_f((xyz[0] * 1000000 + 475244) / 950489);
      fv[1] = lab_f(xyz[1]);
      fv[2] = lab_f((xyz[2] * 1000000 + 544420) / 1088840);
    endfunction

    function bit predict_match(pair_t p);
      longint          f1[3], f2[3], d[3];
      longint unsigned m, q, acc;
      if (p.r1 == p.r2 && p.g1 == p.g2 && p.b1 == p.b2) return 1'b1;
      color_to_f(p.r1, p.g1, p.b1, f1);
      color_to_f(p.r2, p.g2, p.b2, f2);
      d[0] = 116 * (f1[1] - f2[1]);
      d[1] = 500 * ((f1[0] - f2[0]) - (f1[1] - f2[1]));
      d[2] = 200 * ((f1[1] - f2[1]) - (f1[2] - f2[2]));
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        m = (d[i] < 0) ? -d[i] : d[i];
        if (m > (64'd512 << FB)) return 1'b0;
        q = (m + (64'd1 << (FB - 9))) >> (FB - 8);
        acc += q * q;
      end
      return acc <= ((longint'(p.tol) * p.tol) << 16);
    endfunction

    function void note_pair(pair_t p);
      pending.push_back(predict_match(p));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [7:0] data);
      bit want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat tdata=%h", data));
        return;
      end
      want = pending.pop_front();
      if (data[0] !== want) report($sformatf("colours_match=%b expected %b", data[0], want));
      if (data[7:1] !== 7'd0) report($sformatf("pad bits %b not zero", data[7:1]));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  match_scoreboard sb = new();
  int  beats_out = 0;
  int  idle_cycles = 0;
  bit  src_burst = 0;
  bit  snk_burst = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  delta_e_color_match_unit DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  task automatic send_pair(pair_t p);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, p.tol, p.b2, p.g2, p.r2, p.b1, p.g1, p.r1};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pair(p);
    @(negedge clk_i);
  endtask

  function automatic pair_t mk(int r1, int g1, int b1, int r2, int g2, int b2, int tol);
    pair_t p;
    p.r1 = 8'(r1); p.g1 = 8'(g1); p.b1 = 8'(b1);
    p.r2 = 8'(r2); p.g2 = 8'(g2); p.b2 = 8'(b2); p.tol = 9'(tol);
    return p;
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 12)) - 6;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    kind;
    kind = $urandom_range(0, 9);
    p.r1 = 8'($urandom); p.g1 = 8'($urandom); p.b1 = 8'($urandom);
    p.r2 = 8'($urandom); p.g2 = 8'($urandom); p.b2 = 8'($urandom);
    p.tol = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 40));
    if (kind == 0) begin
      p.r2 = p.r1; p.g2 = p.g1; p.b2 = p.b1;
    end else if (kind < 6) begin
      p.r2 = nudge(p.r1); p.g2 = nudge(p.g1); p.b2 = nudge(p.b1);
    end else if (kind == 6) begin
      p.r1 = 8'($urandom_range(0, 20));
      p.g1 = 8'($urandom_range(0, 20));
      p.b1 = 8'($urandom_range(0, 20));
      p.r2 = nudge(p.r1); p.g2 = nudge(p.g1); p.b2 = nudge(p.b1);
    end
    return p;
  endfunction

  initial begin : stimulus
    pair_t dir[$];
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    dir = '{mk(0,0,0, 0,0,0, 0), mk(255,255,255, 255,255,255, 0),
            mk(0,0,0, 255,255,255, 0), mk(0,0,0, 255,255,255, 511),
            mk(0,0,0, 255,255,255, 100), mk(0,0,0, 255,255,255, 99),
            mk(255,0,0, 0,0,255, 511), mk(0,255,0, 255,0,255, 511),
            mk(255,0,0, 0,255,0, 170), mk(10,10,10, 11,11,11, 0),
            mk(10,10,10, 11,11,11, 1), mk(0,0,1, 0,0,0, 0),
            mk(1,0,0, 0,0,0, 1), mk(128,128,128, 129,128,128, 0),
            mk(128,128,128, 129,128,128, 1), mk(200,100,50, 201,99,51, 2),
            mk(0,0,255, 255,255,0, 511), mk(255,255,0, 0,0,255, 200),
            mk(5,3,0, 0,3,5, 3), mk(170,85,255, 85,170,0, 256)};
    src_burst = 1;
    foreach (dir[i]) send_pair(dir[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) src_burst = ($urandom_range(0, 3) == 0);
      send_pair(rand_pair());
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin : sink
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (beats_out % 40 == 0) snk_burst = ($urandom_range(0, 3) == 0);
      stall = snk_burst ? 0 : $urandom_range(0, 10);
      if (beats_out == 300) stall = 400;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
      beats_out++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

endmodule
